[rtl/conv9x9_relu_conv1x1_relu_unit_macros.svh]
// Assertion macros used by the RTL.
`ifndef CONV9X9_RELU_CONV1X1_RELU_UNIT_MACROS_SVH
`define CONV9X9_RELU_CONV1X1_RELU_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define C9_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define C9_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/c9r1_pkg.sv]
`timescale 1ns / 1ps
package c9r1_pkg;
  localparam int MaxWidth      = 64;
  localparam int MaxHeight     = 64;
  localparam int FirstFilters  = 64;
  localparam int SecondFilters = 32;
  localparam int KernelSize    = 9;
  localparam int Half          = KernelSize / 2;
  localparam int FrameDepth    = MaxWidth * MaxHeight;
  localparam int B1Base        = FirstFilters * KernelSize * KernelSize;
  localparam int K2Base        = B1Base + FirstFilters;
  localparam int B2Base        = K2Base + SecondFilters * FirstFilters;
  localparam int WeightDepth   = B2Base + SecondFilters;
  localparam logic [23:0] ActMax = 24'hFFFFFF;

  localparam logic [1:0] REQ_PIXEL   = 2'd0;
  localparam logic [1:0] REQ_WEIGHT  = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         row;
    logic [5:0]         col;
    logic [7:0]         pixel;
    logic [12:0]        weight_index;
    logic signed [15:0] weight_value;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  channel;
    logic [23:0] value;
    logic        last;
    logic        error;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_L1_ADDR, ST_L1_MAC, ST_L1_BIAS, ST_L1_BWAIT, ST_L1_DONE,
    ST_L2_MAC, ST_L2_BIAS, ST_L2_BWAIT, ST_L2_DONE
  } state_t;
endpackage

[rtl/conv9x9_relu_conv1x1_relu_unit.sv]
`timescale 1ns / 1ps
// Two CNN layers (9x9 conv + ReLU, 1x1 conv + ReLU) for one output pixel.
// Input channel: start/busy. A transaction is taken when start is high and
// busy is low. Pixel writes (req_type 0) and weight writes (req_type 1) fill
// the frame store and weight store and give no result.
// A compute transaction (req_type 2) produces 32 results, each shown on
// out_item for one cycle with out_valid high; last marks the final channel.
// A pixel outside the configured size yields one error result instead,
// registered as the sequencer leaves the address state (ST_L1_ADDR) for idle.
// One shared 25x16 signed multiply-accumulate serves both layers, one product
// per cycle in the MAC states, behind a registered store read. Busy stays
// high for the whole compute, so no new transaction is taken until it is
// done; the last result is shown in the first idle cycle.
// Configuration (cfg_we, cfg_index, cfg_data) sets image_width/height; write
// only while idle. Reset (rst_n low, synchronous) returns the sequencer to
// idle and sizes to 64; the stores are not cleared and must be written
// before use. The receiver cannot stall: results are never held.
`include "conv9x9_relu_conv1x1_relu_unit_macros.svh"
module conv9x9_relu_conv1x1_relu_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  c9r1_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output c9r1_pkg::out_item_t  out_item,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [6:0]           cfg_data
);
  import c9r1_pkg::*;

  logic [7:0]         frame_mem [FrameDepth];
  logic signed [15:0] weight_mem [WeightDepth];
  logic signed [24:0] act_mem [FirstFilters];

  state_t state_r, state_nxt;
  logic [6:0] width_r, height_r;
  logic [5:0] row_r, col_r;
  logic [6:0] w_eff, h_eff;
  logic [5:0] k_r;       // filter index
  logic [3:0] i_r, j_r;  // kernel position
  logic [5:0] n_r;       // layer-2 input index
  logic       issue_r;   // read pipeline valid bit
  logic [7:0]         px_rd_r;
  logic signed [15:0] wt_rd_r;
  logic signed [24:0] act_rd_r;
  logic signed [47:0] acc_r;
  logic               l2_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic in_fire;
  assign in_fire = start && (state_r == ST_IDLE);
  assign w_eff = (width_r > 7'(MaxWidth)) ? 7'(MaxWidth) : width_r;
  assign h_eff = (height_r > 7'(MaxHeight)) ? 7'(MaxHeight) : height_r;

  // clamped coordinates
  logic signed [7:0] r_s, c_s;
  logic [5:0] r_c, c_c;
  always_comb begin
    r_s = $signed({2'b00, row_r}) + $signed({4'b0000, i_r}) - 8'sd4;
    c_s = $signed({2'b00, col_r}) + $signed({4'b0000, j_r}) - 8'sd4;
    if (r_s < 0) r_c = '0;
    else if (r_s > $signed({1'b0, h_eff}) - 8'sd1) r_c = 6'(h_eff - 7'd1);
    else r_c = r_s[5:0];
    if (c_s < 0) c_c = '0;
    else if (c_s > $signed({1'b0, w_eff}) - 8'sd1) c_c = 6'(w_eff - 7'd1);
    else c_c = c_s[5:0];
  end

  logic mac_step;
  logic [12:0] w_addr;
  always_comb begin
    mac_step = (state_r == ST_L1_MAC) || (state_r == ST_L2_MAC);
    case (state_r)
      ST_L1_MAC:  w_addr = 13'((32'(k_r) * KernelSize + 32'(i_r)) * KernelSize + 32'(j_r));
      // hold the bias address so the bias is still on the read port at DONE
      ST_L1_BIAS, ST_L1_BWAIT: w_addr = 13'(B1Base + 32'(k_r));
      ST_L2_MAC:  w_addr = 13'(K2Base + 32'(k_r[4:0]) * FirstFilters + 32'(n_r));
      ST_L2_BIAS, ST_L2_BWAIT: w_addr = 13'(B2Base + 32'(k_r[4:0]));
      default:    w_addr = '0;
    endcase
  end

  // stores
  always_ff @(posedge clk) begin
    if (in_fire && in_item.req_type == REQ_PIXEL)
      frame_mem[{in_item.row, in_item.col}] <= in_item.pixel;
    if (in_fire && in_item.req_type == REQ_WEIGHT && in_item.weight_index < 13'(WeightDepth))
      weight_mem[in_item.weight_index] <= in_item.weight_value;
    px_rd_r  <= frame_mem[{r_c, c_c}];
    wt_rd_r  <= weight_mem[w_addr];
    act_rd_r <= act_mem[n_r];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (start && in_item.req_type == REQ_COMPUTE)
                     state_nxt = ST_L1_ADDR;
      ST_L1_ADDR:  if (row_r >= h_eff[5:0] && h_eff != 7'(MaxHeight) || h_eff == 7'd0 ||
                       col_r >= w_eff[5:0] && w_eff != 7'(MaxWidth) || w_eff == 7'd0)
                     state_nxt = ST_IDLE;
                   else state_nxt = ST_L1_MAC;
      ST_L1_MAC:   if (i_r == 4'(KernelSize - 1) && j_r == 4'(KernelSize - 1))
                     state_nxt = ST_L1_BIAS;
      ST_L1_BIAS:  state_nxt = ST_L1_BWAIT;
      ST_L1_BWAIT: state_nxt = ST_L1_DONE;
      ST_L1_DONE:  state_nxt = (k_r == 6'(FirstFilters - 1)) ? ST_L2_MAC : ST_L1_MAC;
      ST_L2_MAC:   if (n_r == 6'(FirstFilters - 1)) state_nxt = ST_L2_BIAS;
      ST_L2_BIAS:  state_nxt = ST_L2_BWAIT;
      ST_L2_BWAIT: state_nxt = ST_L2_DONE;
      ST_L2_DONE:  state_nxt = (k_r == 6'(SecondFilters - 1)) ? ST_IDLE : ST_L2_MAC;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  assign busy = (state_r != ST_IDLE);

  // layer finishing arithmetic
  logic signed [47:0] bias_sum;
  logic [23:0] relu1, relu2;
  logic signed [47:0] rnd;
  always_comb begin
    bias_sum = l2_r ? acc_r + (48'(wt_rd_r) <<< 12) : acc_r + 48'(wt_rd_r);
    if (bias_sum < 0) relu1 = '0;
    else if (bias_sum > 48'(ActMax)) relu1 = ActMax;
    else relu1 = bias_sum[23:0];
    rnd = bias_sum + 48'sd2048;
    if (bias_sum <= 0) relu2 = '0;
    else if ((rnd >>> 12) > 48'(ActMax)) relu2 = ActMax;
    else relu2 = rnd[35:12];
  end

  logic signed [40:0] prod;
  assign prod = l2_r ? act_rd_r * wt_rd_r : $signed({17'd0, px_rd_r}) * wt_rd_r;

  logic err_out;
  assign err_out = (state_r == ST_L1_ADDR) && (state_nxt == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      width_r     <= 7'd64;
      height_r    <= 7'd64;
      out_valid_r <= 1'b0;
      issue_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= err_out || (state_r == ST_L2_DONE);
      issue_r     <= mac_step;
      if (cfg_we) begin
        if (cfg_index == CFG_WIDTH) width_r <= cfg_data;
        else height_r <= cfg_data;
      end
      if (err_out) begin
        out_r <= '{channel: 5'd0, value: 24'd0, last: 1'b1, error: 1'b1};
      end else if (state_r == ST_L2_DONE) begin
        out_r <= '{channel: k_r[4:0], value: relu2,
                   last: (k_r == 6'(SecondFilters - 1)), error: 1'b0};
      end
    end
  end

  // counters and accumulator
  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_r <= in_item.row;
      col_r <= in_item.col;
      k_r <= '0; i_r <= '0; j_r <= '0; n_r <= '0;
      l2_r <= 1'b0;
      acc_r <= '0;
    end
    if (issue_r) acc_r <= acc_r + 48'(prod);
    case (state_r)
      ST_L1_MAC: begin
        if (j_r == 4'(KernelSize - 1)) begin
          j_r <= '0;
          i_r <= (i_r == 4'(KernelSize - 1)) ? 4'd0 : i_r + 4'd1;
        end else j_r <= j_r + 4'd1;
      end
      ST_L1_DONE: begin
        act_mem[k_r] <= {1'b0, relu1};
        acc_r <= '0;
        if (k_r == 6'(FirstFilters - 1)) begin
          k_r <= '0; l2_r <= 1'b1;
        end else k_r <= k_r + 6'd1;
      end
      ST_L2_MAC: n_r <= n_r + 6'd1;
      ST_L2_DONE: begin
        acc_r <= '0;
        k_r <= k_r + 6'd1;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `C9_ASSERT_IMPL(a_out_only_when_busy_or_after, out_valid && !out_item.error, !busy || state_r == ST_L2_MAC)
  `C9_ASSERT_NEXT(a_start_busy, start && !busy && in_item.req_type == REQ_COMPUTE, busy)
  `C9_ASSERT_IMPL(a_err_last, out_valid && out_item.error, out_item.last)
endmodule

[sim/conv_result_checker.sv]
`timescale 1ns / 1ps
module conv_result_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  c9r1_pkg::in_item_t   in_item,
  input  logic                 out_valid,
  input  c9r1_pkg::out_item_t  out_item,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [6:0]           cfg_data,
  output int                   n_fail,
  output int                   n_pending
);
  import c9r1_pkg::*;

  logic [7:0]         frame_mem [FrameDepth];
  logic signed [15:0] coef_mem  [WeightDepth];
  logic [6:0]         width_reg;
  logic [6:0]         height_reg;
  longint             act1 [FirstFilters];
  out_item_t          channel_q [$];

  initial begin
    n_fail = 0;
    n_pending = 0;
    width_reg = 7'd64;
    height_reg = 7'd64;
  end

  // Apply one accepted transaction to the store copies and queue its results.
  task automatic model_request(input in_item_t it);
    int w, h, r, c;
    longint sum, res;
    out_item_t o;
    case (it.req_type)
      REQ_PIXEL: frame_mem[it.row * MaxWidth + it.col] = it.pixel;
      REQ_WEIGHT: begin
        if (it.weight_index < WeightDepth) coef_mem[it.weight_index] = it.weight_value;
      end
      REQ_COMPUTE: begin
        w = (width_reg > MaxWidth) ? MaxWidth : width_reg;
        h = (height_reg > MaxHeight) ? MaxHeight : height_reg;
        if (it.row >= h || it.col >= w) begin
          o.channel = '0;
          o.value = '0;
          o.last = 1'b1;
          o.error = 1'b1;
          channel_q.push_back(o);
        end else begin
          for (int k = 0; k < FirstFilters; k++) begin
            sum = 0;
            for (int i = 0; i < KernelSize; i++) begin
              r = it.row + i - Half;
              if (r < 0) r = 0;
              if (r > h - 1) r = h - 1;
              for (int j = 0; j < KernelSize; j++) begin
                c = it.col + j - Half;
                if (c < 0) c = 0;
                if (c > w - 1) c = w - 1;
                sum += longint'(coef_mem[(k * KernelSize + i) * KernelSize + j])
                       * longint'(frame_mem[r * MaxWidth + c]);
              end
            end
            sum += longint'(coef_mem[B1Base + k]);
            if (sum < 0) sum = 0;
            if (sum > longint'(ActMax)) sum = longint'(ActMax);
            act1[k] = sum;
          end
          for (int k = 0; k < SecondFilters; k++) begin
            sum = 0;
            for (int i = 0; i < FirstFilters; i++)
              sum += act1[i] * longint'(coef_mem[K2Base + k * FirstFilters + i]);
            sum += longint'(coef_mem[B2Base + k]) * 4096;
            if (sum <= 0) res = 0;
            else begin
              res = (sum + 2048) >>> 12;
              if (res > longint'(ActMax)) res = longint'(ActMax);
            end
            o.channel = k[4:0];
            o.value = res[23:0];
            o.last = (k == SecondFilters - 1);
            o.error = 1'b0;
            channel_q.push_back(o);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst_n) begin
      width_reg = 7'd64;
      height_reg = 7'd64;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
      end
      if (out_valid) begin
        if (channel_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("unexpected result: %p", out_item);
        end else begin
          exp_item = channel_q.pop_front();
          if (out_item.channel !== exp_item.channel || out_item.value !== exp_item.value ||
              out_item.last !== exp_item.last || out_item.error !== exp_item.error) begin
            n_fail++;
            if (n_fail <= 10)
              $display("mismatch: expected ch %0d val %0d last %0b err %0b, got ch %0d val %0d last %0b err %0b",
                       exp_item.channel, exp_item.value, exp_item.last, exp_item.error,
                       out_item.channel, out_item.value, out_item.last, out_item.error);
          end
        end
      end
      if (start && !busy) model_request(in_item);
    end
    n_pending = channel_q.size();
  end
endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import c9r1_pkg::*;

  localparam int CycleLimit = 3000000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_we;
  logic      cfg_index;
  logic [6:0] cfg_data;
  int        n_fail;
  int        n_pending;
  int        cycle_count;
  bit        no_gaps;

  conv9x9_relu_conv1x1_relu_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  conv_result_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .n_fail(n_fail), .n_pending(n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Present one transaction from a falling edge and hold it until taken.
  task automatic issue_request(input in_item_t it);
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < 7) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_item = it;
    do @(posedge clk); while (busy);
  endtask

  function automatic in_item_t make_req(input logic [1:0] kind, input int r, input int c,
                                        input int px, input int idx, input int val);
    in_item_t it;
    it.req_type = kind;
    it.row = r[5:0];
    it.col = c[5:0];
    it.pixel = px[7:0];
    it.weight_index = idx[12:0];
    it.weight_value = val[15:0];
    return it;
  endfunction

  function automatic int mild_weight();
    return int'($urandom_range(600)) - 300;
  endfunction

  // Drain every expected result, let the block settle, then write the sizes.
  task automatic set_size(input int w, input int h);
    @(negedge clk);
    start = 1'b0;
    while (n_pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_WIDTH;
    cfg_data = w[6:0];
    @(negedge clk);
    cfg_index = CFG_HEIGHT;
    cfg_data = h[6:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic probe_corners(input int w, input int h);
    issue_request(make_req(REQ_COMPUTE, 0, 0, 0, 0, 0));
    issue_request(make_req(REQ_COMPUTE, h - 1, w - 1, 0, 0, 0));
    issue_request(make_req(REQ_COMPUTE, 63, 63, 0, 0, 0));
    issue_request(make_req(REQ_COMPUTE, 0, w, 0, 0, 0));
  endtask

  initial begin
    in_item_t it;
    int n_items;
    int pick;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    no_gaps = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill both stores so that no compute reads an unwritten entry.
    for (int a = 0; a < FrameDepth; a++)
      issue_request(make_req(REQ_PIXEL, a / MaxWidth, a % MaxWidth, $urandom_range(255), 0, 0));
    no_gaps = 1'b1;
    for (int a = 0; a < WeightDepth; a++)
      issue_request(make_req(REQ_WEIGHT, 0, 0, 0, a, mild_weight()));
    no_gaps = 1'b0;

    // Directed: extremes, ignored requests, borders at reset size.
    issue_request(make_req(REQ_PIXEL, 0, 0, 255, 0, 0));
    issue_request(make_req(REQ_PIXEL, 63, 63, 0, 0, 0));
    issue_request(make_req(REQ_WEIGHT, 0, 0, 0, 0, -32768));
    issue_request(make_req(REQ_WEIGHT, 0, 0, 0, WeightDepth - 1, 32767));
    issue_request(make_req(REQ_WEIGHT, 0, 0, 0, 8191, 1234));
    issue_request(make_req(2'd3, 63, 63, 255, 8191, -1));
    probe_corners(64, 64);
    // Hold the sender until everything is out.
    @(negedge clk);
    start = 1'b0;
    while (n_pending != 0) @(negedge clk);

    set_size(1, 1);
    issue_request(make_req(REQ_PIXEL, 40, 40, 77, 0, 0));
    probe_corners(1, 1);
    set_size(0, 64);
    issue_request(make_req(REQ_COMPUTE, 0, 0, 0, 0, 0));
    set_size(127, 9);
    probe_corners(64, 9);
    issue_request(make_req(REQ_WEIGHT, 0, 0, 0, B2Base, 32767));
    issue_request(make_req(REQ_COMPUTE, 4, 30, 0, 0, 0));

    // Random part over several sizes; the middle stretch runs without gaps.
    n_items = 0;
    while (n_items < 100) begin
      if (n_items % 25 == 0)
        set_size($urandom_range(9, 64), $urandom_range(9, 64));
      no_gaps = (n_items >= 40 && n_items < 55);
      pick = $urandom_range(99);
      it = make_req(REQ_PIXEL, $urandom_range(63), $urandom_range(63), $urandom_range(255),
                    $urandom_range(8191), mild_weight());
      if (pick < 35) it.req_type = REQ_COMPUTE;
      else if (pick < 60) it.req_type = REQ_WEIGHT;
      else if (pick < 90) it.req_type = REQ_PIXEL;
      else it.req_type = 2'd3;
      if ($urandom_range(3) == 0) it.weight_value = 16'($urandom_range(65535));
      if (it.req_type == REQ_WEIGHT && $urandom_range(3) != 0)
        it.weight_index = 13'($urandom_range(WeightDepth - 1));
      issue_request(it);
      if (it.req_type != 2'd3) n_items++;
    end

    @(negedge clk);
    start = 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (n_fail == 0 && n_pending == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl
rtl/c9r1_pkg.sv
rtl/conv9x9_relu_conv1x1_relu_unit.sv
sim/conv_result_checker.sv
sim/testbench.sv
